// ----- hdl/wst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_pkg
// Shared constants, codes and control types for the work-stealing queues.
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int WORKERS     = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int W_BITS      = $clog2(WORKERS);
  localparam int P_BITS      = $clog2(QUEUE_DEPTH);
  localparam int C_BITS      = P_BITS + 1;
  localparam int N_BITS      = W_BITS + 1;

  // Only the low 24 bits of the generator ever matter.
  localparam logic [23:0] LCG_MUL   = 24'(1140671485);
  localparam logic [23:0] LCG_ADD   = 24'(12820163);
  localparam logic [23:0] SEED_INIT = 24'(123456789);
  localparam logic [1:0]  MOD_STEPS = 2'd3;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_INIT_FRONT = 3'd1;
  localparam logic [2:0] FUNC_INIT_BACK  = 3'd2;
  localparam logic [2:0] FUNC_DIST       = 3'd3;
  localparam logic [2:0] FUNC_FETCH      = 3'd4;

  localparam logic [1:0] CFG_NUM_WORKERS    = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_QUEUE  = 2'd1;
  localparam logic [1:0] CFG_STEAL_ATTEMPTS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_TASK = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic [1:0] SRC_ASSEMBLY = 2'd0;
  localparam logic [1:0] SRC_OWN      = 2'd1;
  localparam logic [1:0] SRC_STOLEN   = 2'd2;
  localparam logic [1:0] SRC_NONE     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_DIST, S_DRAW, S_MODS, S_CHECK, S_RESP
  } wst_state_e;

  typedef enum logic [3:0] {
    R_BAD, R_PUSH_OK, R_PUSH_FULL, R_DIST_OK, R_DIST_FULL,
    R_ASM, R_OWN, R_STEAL, R_NONE
  } wst_resp_e;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      dist_init;
    logic      dist_write;
    logic      pop_asm;
    logic      pop_rdy;
    logic      lcg_step;
    logic      mod_step;
    logic      try_inc;
    logic      steal;
    logic      resp_load;
    wst_resp_e resp;
  } wst_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_dist;
    logic is_fetch;
    logic q_bad;
    logic push_full;
    logic dist_bad;
    logic dist_full;
    logic dist_last;
    logic wk_bad;
    logic asm_ne;
    logic rdy_ne;
    logic multi;
    logic mod_done;
    logic victim_self;
    logic tries_done;
    logic out_free;
  } wst_sts_t;

endpackage

// ----- hdl/wst_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_intf
// Request and response channels of the work-stealing queues.
// ----------------------------------------------------------------------------
interface wst_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [2:0]  worker;
  logic [15:0] task_id;
  logic [2:0]  target_queue;
  logic        target_given;
  logic [3:0]  width;
  modport source(output valid, func, worker, task_id, target_queue, target_given, width,
                 input ready);
  modport sink(input valid, func, worker, task_id, target_queue, target_given, width,
               output ready);
endinterface

interface wst_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] task_out;
  logic [1:0]  task_source;
  logic [2:0]  queue_index;
  logic [31:0] steal_total;
  modport source(output valid, status, task_out, task_source, queue_index, steal_total,
                 input ready);
  modport sink(input valid, status, task_out, task_source, queue_index, steal_total,
               output ready);
endinterface

// ----- hdl/wst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_ctrl
// Sequencer that steps one request through decode, distribution and stealing.
// ----------------------------------------------------------------------------
module wst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wst_pkg::wst_sts_t sts_i,
  output wst_pkg::wst_cmd_t cmd_o
);
  import wst_pkg::*;

  wst_state_e state_q, state_d;
  wst_resp_e  resp_q, resp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= R_BAD;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_RESP;
        priority if (sts_i.is_push) begin
          priority if (sts_i.q_bad) resp_d = R_BAD;
          else if (sts_i.push_full) resp_d = R_PUSH_FULL;
          else resp_d = R_PUSH_OK;
        end else if (sts_i.is_dist) begin
          priority if (sts_i.dist_bad) resp_d = R_BAD;
          else if (sts_i.dist_full) resp_d = R_DIST_FULL;
          else state_d = S_DIST;
        end else if (sts_i.is_fetch) begin
          priority if (sts_i.wk_bad) resp_d = R_BAD;
          else if (sts_i.asm_ne) resp_d = R_ASM;
          else if (sts_i.rdy_ne) resp_d = R_OWN;
          else if (sts_i.multi) state_d = S_DRAW;
          else resp_d = R_NONE;
        end else begin
          resp_d = R_BAD;
        end
      end
      S_DIST: begin
        if (sts_i.dist_last) begin
          resp_d  = R_DIST_OK;
          state_d = S_RESP;
        end
      end
      S_DRAW: state_d = S_MODS;
      S_MODS: begin
        if (sts_i.mod_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts_i.victim_self) state_d = S_DRAW;
        else if (sts_i.rdy_ne) begin
          resp_d  = R_STEAL;
          state_d = S_RESP;
        end else if (sts_i.tries_done) begin
          resp_d  = R_NONE;
          state_d = S_RESP;
        end else state_d = S_DRAW;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.resp = resp_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_DECODE: begin
        priority if (sts_i.is_push) begin
          cmd_o.push = !sts_i.q_bad && !sts_i.push_full;
        end else if (sts_i.is_dist) begin
          cmd_o.dist_init = !sts_i.dist_bad && !sts_i.dist_full;
        end else if (sts_i.is_fetch) begin
          cmd_o.pop_asm = !sts_i.wk_bad && sts_i.asm_ne;
          cmd_o.pop_rdy = !sts_i.wk_bad && !sts_i.asm_ne && sts_i.rdy_ne;
        end else begin
          cmd_o.load = 1'b0;
        end
      end
      S_DIST:  cmd_o.dist_write = 1'b1;
      S_DRAW:  cmd_o.lcg_step = 1'b1;
      S_MODS:  cmd_o.mod_step = !sts_i.mod_done;
      S_CHECK: begin
        cmd_o.steal   = !sts_i.victim_self && sts_i.rdy_ne;
        cmd_o.try_inc = !sts_i.victim_self && !sts_i.rdy_ne && !sts_i.tries_done;
      end
      S_RESP:  cmd_o.resp_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/wst_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_dpath
// Queue stores, pointers, victim generator and result register.
// ----------------------------------------------------------------------------
module wst_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wst_pkg::wst_cmd_t cmd_i,
  output wst_pkg::wst_sts_t sts_o,
  input  logic [2:0]        func_i,
  input  logic [2:0]        worker_i,
  input  logic [15:0]       task_id_i,
  input  logic [2:0]        target_queue_i,
  input  logic              target_given_i,
  input  logic [3:0]        width_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [3:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [15:0]       task_out_o,
  output logic [1:0]        source_o,
  output logic [2:0]        queue_index_o,
  output logic [31:0]       steal_total_o
);
  import wst_pkg::*;

  logic [2:0]  func_q;
  logic [2:0]  wk_q;
  logic [15:0] task_q;
  logic [2:0]  tq_q;
  logic        given_q;
  logic [3:0]  width_q;

  logic [3:0]  num_workers_q;
  logic [2:0]  default_queue_q;
  logic [3:0]  steal_attempts_q;

  logic [P_BITS-1:0] rdy_head_q [WORKERS];
  logic [C_BITS-1:0] rdy_cnt_q  [WORKERS];
  logic [P_BITS-1:0] asm_head_q [WORKERS];
  logic [C_BITS-1:0] asm_cnt_q  [WORKERS];
  logic [23:0]       seed_q     [WORKERS];
  logic [15:0]       rdy_mem    [WORKERS*QUEUE_DEPTH];
  logic [15:0]       asm_mem    [WORKERS*QUEUE_DEPTH];
  logic [15:0]       rdy_rd_q, asm_rd_q;

  logic [W_BITS-1:0] idx_q;
  logic [3:0]        r_q;
  logic [1:0]        k_q;
  logic              steal_q;
  logic [3:0]        tries_q;
  logic [31:0]       steals_q;
  logic              out_valid_q;

  logic [N_BITS-1:0] nw;
  logic [W_BITS-1:0] q, row, leader, v;
  logic [3:0]        wrem;
  logic [4:0]        span_end;
  logic              dist_full;
  logic [P_BITS-1:0] rh, ah, front_ptr, back_ptr, steal_ptr, asm_tail;
  logic [C_BITS-1:0] rc, ac;
  logic [23:0]       seed_wk, seed_next;
  logic [7:0]        slice;
  logic [3:0]        r_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_workers_q    <= 4'(WORKERS);
      default_queue_q  <= 3'd0;
      steal_attempts_q <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_WORKERS:    num_workers_q    <= cfg_data_i;
        CFG_DEFAULT_QUEUE:  default_queue_q  <= cfg_data_i[2:0];
        CFG_STEAL_ATTEMPTS: steal_attempts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      wk_q    <= worker_i;
      task_q  <= task_id_i;
      tq_q    <= target_queue_i;
      given_q <= target_given_i;
      width_q <= width_i;
    end
  end

  always_comb begin
    priority if (num_workers_q == 4'd0) nw = N_BITS'(1);
    else if (num_workers_q > 4'(WORKERS)) nw = N_BITS'(WORKERS);
    else nw = N_BITS'(num_workers_q);
  end

  assign q = given_q ? tq_q : ((func_q == FUNC_PUSH_FRONT) ? wk_q : default_queue_q);
  assign v = r_q[W_BITS-1:0];

  always_comb begin
    priority if (func_q == FUNC_DIST) row = idx_q;
    else if (func_q == FUNC_FETCH) row = steal_q ? v : wk_q;
    else row = q;
  end

  // The group leader is the worker index less its remainder by the width.
  always_comb begin
    wrem = '0;
    for (int i = 2; i >= 0; i--) begin
      wrem = {wrem[2:0], wk_q[i]};
      if (wrem >= width_q) wrem = wrem - width_q;
    end
  end
  assign leader   = wk_q - wrem[2:0];
  assign span_end = {2'b00, leader} + {1'b0, width_q};

  always_comb begin
    dist_full = 1'b0;
    for (int i = 0; i < WORKERS; i++) begin
      if (5'(i) >= {2'b00, leader} && 5'(i) < span_end &&
          asm_cnt_q[i] == C_BITS'(QUEUE_DEPTH))
        dist_full = 1'b1;
    end
  end

  assign rh        = rdy_head_q[row];
  assign rc        = rdy_cnt_q[row];
  assign ah        = asm_head_q[row];
  assign ac        = asm_cnt_q[row];
  assign front_ptr = rh - P_BITS'(1);
  assign back_ptr  = rh + rc[P_BITS-1:0];
  assign steal_ptr = back_ptr - P_BITS'(1);
  assign asm_tail  = ah + ac[P_BITS-1:0];

  always_comb begin
    sts_o             = '0;
    sts_o.is_push     = (func_q <= FUNC_INIT_BACK);
    sts_o.is_dist     = (func_q == FUNC_DIST);
    sts_o.is_fetch    = (func_q == FUNC_FETCH);
    sts_o.q_bad       = ({1'b0, q} >= nw);
    sts_o.push_full   = (rc == C_BITS'(QUEUE_DEPTH));
    sts_o.wk_bad      = ({1'b0, wk_q} >= nw);
    sts_o.dist_bad    = (width_q == 4'd0) || sts_o.wk_bad || (span_end > {1'b0, nw});
    sts_o.dist_full   = dist_full;
    sts_o.dist_last   = ({2'b00, idx_q} + 5'd1) == span_end;
    sts_o.asm_ne      = (ac != '0);
    sts_o.rdy_ne      = (rc != '0);
    sts_o.multi       = (nw > N_BITS'(1));
    sts_o.mod_done    = (k_q == MOD_STEPS);
    sts_o.victim_self = (v == wk_q);
    sts_o.tries_done  = (tries_q == steal_attempts_q);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORKERS; i++) begin
        rdy_head_q[i] <= '0;
        rdy_cnt_q[i]  <= '0;
        asm_head_q[i] <= '0;
        asm_cnt_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.push) begin
        if (func_q != FUNC_INIT_BACK) rdy_head_q[row] <= front_ptr;
        rdy_cnt_q[row] <= rc + C_BITS'(1);
      end
      if (cmd_i.pop_rdy) begin
        rdy_head_q[row] <= rh + P_BITS'(1);
        rdy_cnt_q[row]  <= rc - C_BITS'(1);
      end
      if (cmd_i.steal) rdy_cnt_q[row] <= rc - C_BITS'(1);
      if (cmd_i.dist_write) asm_cnt_q[row] <= ac + C_BITS'(1);
      if (cmd_i.pop_asm) begin
        asm_head_q[row] <= ah + P_BITS'(1);
        asm_cnt_q[row]  <= ac - C_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push)
      rdy_mem[{row, (func_q == FUNC_INIT_BACK) ? back_ptr : front_ptr}] <= task_q;
    if (cmd_i.pop_rdy) rdy_rd_q <= rdy_mem[{row, rh}];
    else if (cmd_i.steal) rdy_rd_q <= rdy_mem[{row, steal_ptr}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_write) asm_mem[{row, asm_tail}] <= task_q;
    if (cmd_i.pop_asm) asm_rd_q <= asm_mem[{row, ah}];
  end

  assign seed_wk   = seed_q[wk_q];
  assign seed_next = seed_wk * LCG_MUL + LCG_ADD;

  always_comb begin
    unique case (k_q)
      2'd0:    slice = seed_wk[23:16];
      2'd1:    slice = seed_wk[15:8];
      default: slice = seed_wk[7:0];
    endcase
    r_next = r_q;
    for (int i = 7; i >= 0; i--) begin
      r_next = {r_next[2:0], slice[i]};
      if (r_next >= 4'(nw)) r_next = r_next - 4'(nw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORKERS; i++) seed_q[i] <= SEED_INIT;
      steals_q <= '0;
      steal_q  <= 1'b0;
      tries_q  <= '0;
      r_q      <= '0;
      k_q      <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        steal_q <= 1'b0;
        tries_q <= '0;
      end
      if (cmd_i.lcg_step) begin
        seed_q[wk_q] <= seed_next;
        steal_q      <= 1'b1;
        r_q          <= '0;
        k_q          <= '0;
      end
      if (cmd_i.mod_step) begin
        r_q <= r_next;
        k_q <= k_q + 2'd1;
      end
      if (cmd_i.try_inc) tries_q <= tries_q + 4'd1;
      if (cmd_i.steal) steals_q <= steals_q + 32'd1;
      if (cmd_i.dist_init) idx_q <= leader;
      else if (cmd_i.dist_write) idx_q <= idx_q + W_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.resp_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      steal_total_o <= steals_q;
      task_out_o    <= '0;
      source_o      <= SRC_NONE;
      queue_index_o <= '0;
      unique case (cmd_i.resp)
        R_PUSH_OK: begin
          status_o <= ST_OK;  queue_index_o <= q;
        end
        R_PUSH_FULL: begin
          status_o <= ST_FULL;  queue_index_o <= q;
        end
        R_DIST_OK: begin
          status_o <= ST_OK;  queue_index_o <= leader;
        end
        R_DIST_FULL: begin
          status_o <= ST_FULL;  queue_index_o <= leader;
        end
        R_ASM: begin
          status_o <= ST_OK;  task_out_o <= asm_rd_q;
          source_o <= SRC_ASSEMBLY;  queue_index_o <= wk_q;
        end
        R_OWN: begin
          status_o <= ST_OK;  task_out_o <= rdy_rd_q;
          source_o <= SRC_OWN;  queue_index_o <= wk_q;
        end
        R_STEAL: begin
          status_o <= ST_OK;  task_out_o <= rdy_rd_q;
          source_o <= SRC_STOLEN;  queue_index_o <= v;
        end
        R_NONE:  status_o <= ST_NO_TASK;
        default: status_o <= ST_BAD;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc <= C_BITS'(QUEUE_DEPTH)) && (ac <= C_BITS'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");
  a_steal_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.steal |=> $stable(steals_q))
    else $error("steal counter moved without a steal");
  a_steal_ne: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.steal |-> (steal_q && rc != '0 && v != wk_q))
    else $error("steal from an empty or own queue");

endmodule

// ----- hdl/work_stealing_task_queues.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_task_queues
// Per-worker ready deques and assembly queues with randomised stealing.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i and one result per request leaves on rsp_o;
// each channel moves an item by a valid/ready transfer. Configuration writes
// (worker count, default queue, steal attempts) go through cfg_we_i while the
// block is idle. One request is worked at a time: a push or a local fetch
// goes from decode straight to its result, and a distribution writes each
// member of the group in turn between the two. A steal draw runs the
// generator update, the byte-serial modulo unit over the three seed bytes,
// a step to see it finished and the victim check, and a fetch may make
// several draws, so its time grows with the redraws and steal attempts.
// req_i.ready is high only when no request is in progress; a finished result
// sits in the output register, and if the receiver stalls the block holds the
// next result until that register has been taken. Reset empties every queue,
// seeds each worker's generator and clears the steal counter; the stores
// themselves are not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
module work_stealing_task_queues (
  input  logic       clk_i,
  input  logic       rst_ni,
  wst_req_if.sink    req_i,
  wst_rsp_if.source  rsp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i
);
  import wst_pkg::*;

  wst_cmd_t cmd;
  wst_sts_t sts;

  // The sequencer decides what happens each cycle; the datapath holds state.
  wst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wst_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (req_i.func),
    .worker_i       (req_i.worker),
    .task_id_i      (req_i.task_id),
    .target_queue_i (req_i.target_queue),
    .target_given_i (req_i.target_given),
    .width_i        (req_i.width),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .task_out_o     (rsp_o.task_out),
    .source_o       (rsp_o.task_source),
    .queue_index_o  (rsp_o.queue_index),
    .steal_total_o  (rsp_o.steal_total)
  );

endmodule

// ----- tb/sv/work_stealing_task_queues_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_task_queues_tb
// Self-checking bench for the work-stealing task queues. A queue of requests
// is fed through a valid/ready driver. Each accepted request is run through
// a local scheduler model that keeps its own deques, assembly queues, steal
// generators and configuration. A monitor checks every result field against
// the oldest predicted result. The run walks through several configurations,
// the extreme ones among them, with random idling on both channels.
// ----------------------------------------------------------------------------
module work_stealing_task_queues_tb;
  import wst_pkg::*;

  localparam int IDLE_PCT   = 26;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]  func;
    logic [2:0]  worker;
    logic [15:0] task_id;
    logic [2:0]  target_queue;
    logic        target_given;
    logic [3:0]  width;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] task_out;
    logic [1:0]  source;
    logic [2:0]  queue_index;
    logic [31:0] steal_total;
  } outcome_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [3:0] cfg_data_i;

  wst_req_if req_ch ();
  wst_rsp_if rsp_ch ();

  work_stealing_task_queues u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch.sink),
    .rsp_o     (rsp_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Requests waiting to be driven, and results the scheduler model expects.
  request_t request_backlog[$];
  outcome_t expected_results[$];

  // Scheduler model state, mirroring what the block should hold.
  logic [15:0] ready_mem[WORKERS][QUEUE_DEPTH];
  int          ready_first[WORKERS];
  int          ready_fill[WORKERS];
  logic [15:0] asm_mem[WORKERS][QUEUE_DEPTH];
  int          asm_first[WORKERS];
  int          asm_fill[WORKERS];
  logic [23:0] victim_seed[WORKERS];
  logic [31:0] steal_count;

  // Configuration as last written.
  logic [3:0] cfg_workers;
  logic [2:0] cfg_default_q;
  logic [3:0] cfg_steal_tries;

  int  mismatches;
  int  cycle_count;
  int  quiet_cycles;
  logic quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The idling windows repeat, and each window opens running flat out on both
  // channels so that back-to-back transfers occur.
  assign quiet = (cycle_count % 2000) < 300;

  function automatic int active_count();
    if (cfg_workers == 4'd0) return 1;
    if (cfg_workers > WORKERS) return WORKERS;
    return int'(cfg_workers);
  endfunction

  // Works out the result of one accepted request and updates the model state.
  function automatic outcome_t schedule_request(request_t r);
    outcome_t   o;
    int         nw;
    int         q;
    int         leader;
    int         span;
    int         v;
    int         wk;
    logic [47:0] prod;
    nw = active_count();
    wk = int'(r.worker);
    o.status = ST_BAD;
    o.task_out = 16'd0;
    o.source = SRC_NONE;
    o.queue_index = 3'd0;
    case (r.func)
      FUNC_PUSH_FRONT, FUNC_INIT_FRONT, FUNC_INIT_BACK: begin
        if (r.target_given) q = int'(r.target_queue);
        else if (r.func == FUNC_PUSH_FRONT) q = wk;
        else q = int'(cfg_default_q);
        if (q < nw) begin
          o.queue_index = 3'(q);
          if (ready_fill[q] >= QUEUE_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            if (r.func == FUNC_INIT_BACK) begin
              ready_mem[q][(ready_first[q] + ready_fill[q]) % QUEUE_DEPTH] = r.task_id;
            end else begin
              ready_first[q] = (ready_first[q] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
              ready_mem[q][ready_first[q]] = r.task_id;
            end
            ready_fill[q]++;
            o.status = ST_OK;
          end
        end
      end
      FUNC_DIST: begin
        span = int'(r.width);
        if (span != 0 && wk < nw) begin
          leader = (wk / span) * span;
          if (leader + span <= nw) begin
            o.queue_index = 3'(leader);
            o.status = ST_OK;
            for (int i = leader; i < leader + span; i++)
              if (asm_fill[i] >= QUEUE_DEPTH) o.status = ST_FULL;
            if (o.status == ST_OK) begin
              for (int i = leader; i < leader + span; i++) begin
                asm_mem[i][(asm_first[i] + asm_fill[i]) % QUEUE_DEPTH] = r.task_id;
                asm_fill[i]++;
              end
            end
          end
        end
      end
      FUNC_FETCH: begin
        if (wk < nw) begin
          o.status = ST_NO_TASK;
          if (asm_fill[wk] != 0) begin
            o = '{ST_OK, asm_mem[wk][asm_first[wk]], SRC_ASSEMBLY, 3'(wk), 32'd0};
            asm_first[wk] = (asm_first[wk] + 1) % QUEUE_DEPTH;
            asm_fill[wk]--;
          end else if (ready_fill[wk] != 0) begin
            o = '{ST_OK, ready_mem[wk][ready_first[wk]], SRC_OWN, 3'(wk), 32'd0};
            ready_first[wk] = (ready_first[wk] + 1) % QUEUE_DEPTH;
            ready_fill[wk]--;
          end else if (nw > 1) begin
            // Each try draws victims until one other than the caller turns
            // up, then takes the back of that victim's deque if it has one.
            for (int t = 0; t <= int'(cfg_steal_tries); t++) begin
              do begin
                prod = 48'(victim_seed[wk]) * 48'(LCG_MUL) + 48'(LCG_ADD);
                victim_seed[wk] = prod[23:0];
                v = int'(victim_seed[wk] % 24'(nw));
              end while (v == wk);
              if (ready_fill[v] != 0) begin
                o = '{ST_OK, ready_mem[v][(ready_first[v] + ready_fill[v] - 1) % QUEUE_DEPTH],
                      SRC_STOLEN, 3'(v), 32'd0};
                ready_fill[v]--;
                steal_count++;
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    o.steal_total = steal_count;
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
    mismatches++;
  endtask

  // Request driver: a valid that was not yet taken holds with its payload.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.insert(expected_results.size(),
                                schedule_request(request_backlog[0]));
        request_backlog.delete(0);
      end
      if (req_ch.valid && !req_ch.ready) begin
        // Transfer still pending, so everything stays as it is.
      end else if (request_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
      begin
        req_ch.valid        <= 1'b1;
        req_ch.func         <= request_backlog[0].func;
        req_ch.worker       <= request_backlog[0].worker;
        req_ch.task_id      <= request_backlog[0].task_id;
        req_ch.target_queue <= request_backlog[0].target_queue;
        req_ch.target_given <= request_backlog[0].target_given;
        req_ch.width        <= request_backlog[0].width;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: every transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          mismatches++;
        end else begin
          if (rsp_ch.status !== expected_results[0].status)
            report("status", 32'(rsp_ch.status), 32'(expected_results[0].status));
          if (rsp_ch.task_out !== expected_results[0].task_out)
            report("task_out", 32'(rsp_ch.task_out), 32'(expected_results[0].task_out));
          if (rsp_ch.task_source !== expected_results[0].source)
            report("source", 32'(rsp_ch.task_source), 32'(expected_results[0].source));
          if (rsp_ch.queue_index !== expected_results[0].queue_index)
            report("queue_index", 32'(rsp_ch.queue_index),
                   32'(expected_results[0].queue_index));
          if (rsp_ch.steal_total !== expected_results[0].steal_total)
            report("steal_total", rsp_ch.steal_total, expected_results[0].steal_total);
          expected_results.delete(0);
        end
      end
    end
  end

  // Watchdog: too long without any transfer means the block has hung.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[work_stealing_task_queues] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_request(logic [2:0] func, logic [2:0] worker, logic [15:0] task_id,
                             logic [2:0] tq, logic given, logic [3:0] width);
    request_backlog.insert(request_backlog.size(), '{func, worker, task_id, tq, given, width});
  endtask

  // Waits for every request to be taken and every result to arrive, then
  // leaves room for the block to settle before anything else happens.
  task automatic drain();
    @(posedge clk_i);
    while (request_backlog.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [3:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_NUM_WORKERS:    cfg_workers     = value;
      CFG_DEFAULT_QUEUE:  cfg_default_q   = value[2:0];
      CFG_STEAL_ATTEMPTS: cfg_steal_tries = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random requests for one configuration. fetch_pct sets how often the
  // queues are drained, so low values drive them towards full.
  task automatic random_phase(int count, int fetch_pct);
    int nw;
    int pick;
    logic [2:0] func;
    nw = active_count();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) func = 3'($urandom_range(7, 5));
      else if (pick < 3 + fetch_pct) func = FUNC_FETCH;
      else if (pick < 15 + fetch_pct) func = FUNC_DIST;
      else func = 3'($urandom_range(2, 0));
      add_request(func,
                  ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(nw - 1)),
                  16'($urandom),
                  ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(nw - 1)),
                  1'($urandom_range(1)),
                  ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(nw, 1)));
    end
  endtask

  initial begin
    logic [3:0] settings[7][3];
    settings = '{'{4'd1, 4'd0, 4'd0}, '{4'd8, 4'd7, 4'd15}, '{4'd3, 4'd2, 4'd0},
                 '{4'd0, 4'd5, 4'd2}, '{4'd15, 4'd3, 4'd4}, '{4'd5, 4'd4, 4'd3},
                 '{4'd2, 4'd1, 4'd8}};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NUM_WORKERS;
    cfg_data_i = 4'd0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_PUSH_FRONT;
    req_ch.worker = 3'd0;
    req_ch.task_id = 16'd0;
    req_ch.target_queue = 3'd0;
    req_ch.target_given = 1'b0;
    req_ch.width = 4'd1;
    rsp_ch.ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    quiet_cycles = 0;
    // Model state after reset.
    for (int w = 0; w < WORKERS; w++) begin
      ready_first[w] = 0;
      ready_fill[w] = 0;
      asm_first[w] = 0;
      asm_fill[w] = 0;
      victim_seed[w] = SEED_INIT;
    end
    steal_count = 32'd0;
    cfg_workers = 4'd8;
    cfg_default_q = 3'd0;
    cfg_steal_tries = 4'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening under the reset configuration: an empty fetch that
    // has to give up stealing, unknown operations, bad and maximal group
    // widths, the field extremes, and a deque filled until it refuses.
    add_request(FUNC_FETCH, 3'd0, 16'd0, 3'd0, 1'b0, 4'd1);
    add_request(3'd5, 3'd1, 16'hFFFF, 3'd7, 1'b1, 4'd15);
    add_request(3'd6, 3'd2, 16'h0000, 3'd0, 1'b0, 4'd0);
    add_request(3'd7, 3'd7, 16'h5A5A, 3'd7, 1'b1, 4'd8);
    add_request(FUNC_DIST, 3'd7, 16'hFFFF, 3'd0, 1'b0, 4'd8);
    add_request(FUNC_DIST, 3'd3, 16'h1234, 3'd0, 1'b0, 4'd0);
    add_request(FUNC_DIST, 3'd2, 16'h1235, 3'd0, 1'b0, 4'd15);
    add_request(FUNC_DIST, 3'd5, 16'h0001, 3'd0, 1'b0, 4'd3);
    add_request(FUNC_PUSH_FRONT, 3'd7, 16'hFFFF, 3'd0, 1'b0, 4'd1);
    add_request(FUNC_INIT_FRONT, 3'd0, 16'h00FF, 3'd7, 1'b1, 4'd1);
    add_request(FUNC_INIT_BACK, 3'd4, 16'hFF00, 3'd0, 1'b0, 4'd1);
    add_request(FUNC_FETCH, 3'd7, 16'd0, 3'd0, 1'b0, 4'd1);
    add_request(FUNC_FETCH, 3'd7, 16'd0, 3'd0, 1'b0, 4'd1);
    add_request(FUNC_FETCH, 3'd7, 16'd0, 3'd0, 1'b0, 4'd1);
    for (int n = 0; n <= QUEUE_DEPTH; n++)
      add_request(FUNC_INIT_BACK, 3'd6, 16'(16'hA000 + n), 3'd2, 1'b1, 4'd1);
    add_request(FUNC_FETCH, 3'd6, 16'd0, 3'd0, 1'b0, 4'd1);
    random_phase(200, 35);
    drain();

    // Every register is written in each later phase; the list runs from a
    // single worker to out-of-range worker counts and the most steal tries.
    for (int p = 0; p < 7; p++) begin
      write_cfg(CFG_NUM_WORKERS, settings[p][0]);
      write_cfg(CFG_DEFAULT_QUEUE, settings[p][1]);
      write_cfg(CFG_STEAL_ATTEMPTS, settings[p][2]);
      random_phase(205, (p % 2 == 0) ? 20 : 45);
      drain();
    end

    if (mismatches == 0) begin
      $display("[work_stealing_task_queues] OK");
    end else begin
      $display("[work_stealing_task_queues] ERROR");
    end
    $finish;
  end

endmodule
